FILE: rtl/core/sliding_polynomial_smoother_unit_assert.svh
// assertion macros for the rtl, used by sps_controller
// each macro takes a label, clock, reset, antecedent and consequent
`ifndef SLIDING_POLYNOMIAL_SMOOTHER_UNIT_ASSERT_SVH
`define SLIDING_POLYNOMIAL_SMOOTHER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// consequent holds in the same cycle
`define SPS_ASSERT_SAME(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// consequent holds in the following cycle
`define SPS_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define SPS_ASSERT_SAME(lbl, ck, rs, ante, cons)
`define SPS_ASSERT_NEXT(lbl, ck, rs, ante, cons)

`endif

`endif

FILE: rtl/core/sps_pkg.sv
package sps_pkg;

  // window geometry and number formats
  localparam int Window     = 7;
  localparam int Half       = (Window - 1) / 2;
  localparam int SampleBits = 16;
  localparam int FracBits   = 16;
  localparam int CoefBits   = 17;
  localparam int ProdBits   = CoefBits + SampleBits;
  localparam int AccBits    = ProdBits + $clog2(Window);
  localparam int CountBits  = $clog2(Window + 1);
  localparam int RowBits    = $clog2(Window);

  // hat matrix rows, quadratic fit over seven points, q.16
  localparam logic signed [CoefBits-1:0] CoefRom [Window][Window] = '{
    '{ 17'sd49932,  17'sd23406,  17'sd4681,  -17'sd6242, -17'sd9362, -17'sd4681,  17'sd7802},
    '{ 17'sd23406,  17'sd18725,  17'sd14043,  17'sd9362,  17'sd4681,  17'sd0,    -17'sd4681},
    '{ 17'sd4681,   17'sd14043,  17'sd18725,  17'sd18725, 17'sd14043, 17'sd4681, -17'sd9362},
    '{-17'sd6242,   17'sd9362,   17'sd18725,  17'sd21845, 17'sd18725, 17'sd9362, -17'sd6242},
    '{-17'sd9362,   17'sd4681,   17'sd14043,  17'sd18725, 17'sd18725, 17'sd14043, 17'sd4681},
    '{-17'sd4681,   17'sd0,      17'sd4681,   17'sd9362,  17'sd14043, 17'sd18725, 17'sd23406},
    '{ 17'sd7802,  -17'sd4681,  -17'sd9362,  -17'sd6242,  17'sd4681,  17'sd23406, 17'sd49932}
  };

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_ROUND
  } sps_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic               shift;
    logic               mul_en;
    logic               acc_clr;
    logic               acc_en;
    logic               load;
    logic               eor;
    logic [RowBits-1:0] row;
    logic [RowBits-1:0] tap;
  } sps_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;
  } sps_stat_t;

endpackage

FILE: rtl/core/sps_sample_if.sv
interface sps_sample_if import sps_pkg::*; ();

  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] sample;
  logic                         final_sample;

  modport source (output valid, output sample, output final_sample, input ready);
  modport sink   (input valid, input sample, input final_sample, output ready);

endinterface

FILE: rtl/core/sps_result_if.sv
interface sps_result_if import sps_pkg::*; ();

  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] smoothed;
  logic                         end_of_run;

  modport source (output valid, output smoothed, output end_of_run, input ready);
  modport sink   (input valid, input smoothed, input end_of_run, output ready);

endinterface

FILE: rtl/core/sps_datapath.sv
module sps_datapath import sps_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic signed [SampleBits-1:0] sample,
  input  sps_cmd_t                     cmd,
  output sps_stat_t                    stat,
  sps_result_if.source                 results
);

  logic signed [SampleBits-1:0] win [Window];
  logic signed [ProdBits-1:0]   prod;
  logic signed [AccBits-1:0]    acc;
  logic signed [AccBits-1:0]    rnd;
  logic signed [AccBits-1:0]    quo;
  logic signed [SampleBits-1:0] sat;
  logic                         ovf;

  // window shift line, oldest sample at index 0
  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      for (int i = 0; i < Window - 1; i++) begin
        win[i] <= win[i + 1];
      end
      win[Window-1] <= sample;
    end
  end

  // one tap per cycle, product registered before accumulation
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= CoefRom[cmd.row][cmd.tap] * win[cmd.tap];
    end
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (cmd.acc_en) begin
      acc <= acc + AccBits'(prod);
    end
  end

  // round half up, then saturate to the sample range
  always_comb begin
    rnd = acc + (AccBits'(1) <<< (FracBits - 1));
    quo = rnd >>> FracBits;
    ovf = (quo[AccBits-1:SampleBits-1] != '0) && (quo[AccBits-1:SampleBits-1] != '1);
    if (ovf) begin
      sat = quo[AccBits-1] ? {1'b1, {(SampleBits-1){1'b0}}} : {1'b0, {(SampleBits-1){1'b1}}};
    end else begin
      sat = quo[SampleBits-1:0];
    end
  end

  assign stat.out_free = !results.valid || results.ready;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (cmd.load) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      results.smoothed   <= sat;
      results.end_of_run <= cmd.eor;
    end
  end

endmodule

FILE: rtl/core/sps_controller.sv
`include "sliding_polynomial_smoother_unit_assert.svh"

module sps_controller import sps_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_final,
  output logic      in_ready,
  input  sps_stat_t stat,
  output sps_cmd_t  cmd
);

  localparam logic [CountBits-1:0] CountFull = CountBits'(Window);
  localparam logic [RowBits-1:0]   RowHalf   = RowBits'(Half);
  localparam logic [RowBits-1:0]   RowLast   = RowBits'(Window - 1);

  sps_state_t           state, state_next;
  logic [CountBits-1:0] fill_count, fill_count_next;
  logic [CountBits-1:0] tap, tap_next;
  logic [RowBits-1:0]   row, row_next;
  logic [RowBits-1:0]   row_last, row_last_next;
  logic                 fin, fin_next;
  logic                 in_fire;
  logic                 filling;
  logic                 full_after;
  logic                 row_done;

  assign in_fire    = in_valid && in_ready;
  assign filling    = fill_count != CountFull;
  assign full_after = !filling || (fill_count + CountBits'(1) == CountFull);
  assign row_done   = row == row_last;

  // next state and counters
  always_comb begin
    state_next      = state;
    fill_count_next = fill_count;
    tap_next        = tap;
    row_next        = row;
    row_last_next   = row_last;
    fin_next        = fin;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (full_after) begin
            state_next      = ST_MAC;
            fill_count_next = CountFull;
            tap_next        = '0;
            row_next        = filling ? '0 : RowHalf;
            row_last_next   = in_final ? RowLast : RowHalf;
            fin_next        = in_final;
          end else begin
            fill_count_next = in_final ? '0 : fill_count + CountBits'(1);
          end
        end
      end
      ST_MAC: begin
        tap_next = tap + CountBits'(1);
        if (tap == CountFull) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (stat.out_free) begin
          if (row_done) begin
            state_next = ST_IDLE;
            if (fin) begin
              fill_count_next = '0;
            end
          end else begin
            state_next = ST_MAC;
            row_next   = row + RowBits'(1);
            tap_next   = '0;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // command outputs
  always_comb begin
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.row     = row;
    case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.shift = in_valid;
      end
      ST_MAC: begin
        cmd.mul_en  = tap != CountFull;
        cmd.acc_clr = tap == '0;
        cmd.acc_en  = tap != '0;
        cmd.tap     = (tap != CountFull) ? tap[RowBits-1:0] : '0;
      end
      ST_ROUND: begin
        cmd.load = stat.out_free;
        cmd.eor  = fin && row_done;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fill_count <= '0;
      tap        <= '0;
      row        <= '0;
      row_last   <= '0;
      fin        <= 1'b0;
    end else begin
      state      <= state_next;
      fill_count <= fill_count_next;
      tap        <= tap_next;
      row        <= row_next;
      row_last   <= row_last_next;
      fin        <= fin_next;
    end
  end

  // busy only with a full window
  `SPS_ASSERT_SAME(a_busy_full, clk, rst, state != ST_IDLE, fill_count == CountFull)
  // result register loaded only when free
  `SPS_ASSERT_SAME(a_load_free, clk, rst, cmd.load, stat.out_free)
  // row never runs past the last row of this transaction
  `SPS_ASSERT_SAME(a_row_bound, clk, rst, state != ST_IDLE, row <= row_last)
  // accumulation follows the first tap
  `SPS_ASSERT_NEXT(a_acc_follow, clk, rst, cmd.acc_clr, cmd.acc_en)

endmodule

FILE: rtl/core/sliding_polynomial_smoother_unit.sv
// channel   modport  payload
// samples   sink     sample (16 signed), final_sample
// results   source   smoothed (16 signed), end_of_run
//
// each result is built on the single multiply-accumulate unit walking the 7
// window taps, then rounded, saturated and loaded into the result register
// a sample is taken only while idle and causes 1, 4 or 7 results, none while filling
// the result register stalls the sequencer only while it is still occupied
// synchronous reset empties the window and drops any pending result
module sliding_polynomial_smoother_unit import sps_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  sps_sample_if.sink   samples,
  sps_result_if.source results
);

  sps_cmd_t  cmd;
  sps_stat_t stat;

  // sequencer
  sps_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_final (samples.final_sample),
    .in_ready (samples.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // window, mac and result register
  sps_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .sample  (samples.sample),
    .cmd     (cmd),
    .stat    (stat),
    .results (results)
  );

endmodule
